@@ hw/rtl/urm_pkg.sv @@
package urm_pkg;

	typedef enum logic [1:0] {
		FUNC_READ   = 2'd0,
		FUNC_WRITE  = 2'd1,
		FUNC_NOTIFY = 2'd2
	} func_t;

	localparam logic [2:0] OFS_DATA = 3'd0;
	localparam logic [2:0] OFS_IER  = 3'd1;
	localparam logic [2:0] OFS_IIR  = 3'd2;
	localparam logic [2:0] OFS_LCR  = 3'd3;
	localparam logic [2:0] OFS_MCR  = 3'd4;
	localparam logic [2:0] OFS_LSR  = 3'd5;

	localparam logic [7:0] IER_RX_AVAIL = 8'h01;
	localparam logic [7:0] IER_THR_EMPTY = 8'h02;
	localparam logic [7:0] IIR_RX_DATA = 8'h04;
	localparam logic [7:0] IIR_THR_EMPTY = 8'h02;
	localparam logic [7:0] IIR_NONE = 8'h01;
	localparam logic [7:0] LSR_IDLE = 8'h60;
	localparam logic [7:0] LSR_DATA_READY = 8'h01;

	localparam logic [7:0] IER_RESET = 8'h00;
	localparam logic [7:0] LCR_RESET = 8'h03;
	localparam logic [7:0] MCR_RESET = 8'h00;
	localparam logic [7:0] DLL_RESET = 8'h01;
	localparam logic [7:0] DLM_RESET = 8'h00;

	localparam int LCR_DLAB_BIT = 7;

	typedef struct packed {
		func_t      func;
		logic [2:0] reg_offset;
		logic [7:0] write_data;
		logic       rx_valid;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       irq_pulse;
		logic       rx_pop;
	} result_t;

endpackage

@@ hw/rtl/urm_regfile.sv @@
module urm_regfile
	import urm_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    advance,
	input  item_t   item,
	input  logic    irq_route_enable,
	output result_t result
);

	logic [7:0] ier_q;
	logic [7:0] lcr_q;
	logic [7:0] mcr_q;
	logic [7:0] dll_q;
	logic [7:0] dlm_q;

	logic       dlab;
	logic       want_irq;
	logic [7:0] rd;
	logic       pop;
	logic       txv;
	logic [7:0] txb;

	assign dlab = lcr_q[LCR_DLAB_BIT];

	always_comb begin
		rd = 8'h00;
		pop = 1'b0;
		txv = 1'b0;
		txb = 8'h00;
		want_irq = 1'b0;
		unique case (item.func)
			FUNC_READ: begin
				unique case (item.reg_offset)
					OFS_DATA: begin
						if (dlab) begin
							rd = dll_q;
						end else if (item.rx_valid) begin
							rd = item.rx_byte;
							pop = 1'b1;
						end
					end
					OFS_IER: rd = dlab ? dlm_q : ier_q;
					OFS_IIR: begin
						if (item.rx_valid && ((ier_q & IER_RX_AVAIL) != 8'h00)) begin
							rd = IIR_RX_DATA;
						end else if ((ier_q & IER_THR_EMPTY) != 8'h00) begin
							rd = IIR_THR_EMPTY;
						end else begin
							rd = IIR_NONE;
						end
					end
					OFS_LCR: rd = lcr_q;
					OFS_MCR: rd = mcr_q;
					OFS_LSR: rd = item.rx_valid ? (LSR_IDLE | LSR_DATA_READY) : LSR_IDLE;
					default: rd = 8'h00;
				endcase
			end
			FUNC_WRITE: begin
				if (item.reg_offset == OFS_DATA && !dlab) begin
					txv = 1'b1;
					txb = item.write_data;
					want_irq = (ier_q & IER_THR_EMPTY) != 8'h00;
				end else if (item.reg_offset == OFS_IER && !dlab) begin
					want_irq = (item.write_data & IER_THR_EMPTY) != 8'h00;
				end
			end
			FUNC_NOTIFY: want_irq = 1'b1;
			default: ;
		endcase
	end

	assign result.read_data = rd;
	assign result.tx_valid = txv;
	assign result.tx_byte = txb;
	assign result.irq_pulse = want_irq & irq_route_enable;
	assign result.rx_pop = pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ier_q <= IER_RESET;
			lcr_q <= LCR_RESET;
			mcr_q <= MCR_RESET;
			dll_q <= DLL_RESET;
			dlm_q <= DLM_RESET;
		end else if (advance && item.func == FUNC_WRITE) begin
			unique case (item.reg_offset)
				OFS_DATA: if (dlab) dll_q <= item.write_data;
				OFS_IER: begin
					if (dlab) begin
						dlm_q <= item.write_data;
					end else begin
						ier_q <= item.write_data;
					end
				end
				OFS_LCR: lcr_q <= item.write_data;
				OFS_MCR: mcr_q <= item.write_data;
				default: ;
			endcase
		end
	end

endmodule

@@ hw/rtl/uart_register_model.sv @@
// Each transaction is registered on input (item_s1), decoded combinationally and registered on output:
// the result is captured in result_s2 as the input stage advances, which waits while the output
// is stalled by m_axis_tready. Throughput is one transaction per cycle while the output is not stalled;
// register state updates as an item leaves the input stage, so the next item sees it.
// Reset is asynchronous and active low; it restores IER 0x00, LCR 0x03, MCR 0x00, divisor
// 0x0001 and clears interrupt routing.
module uart_register_model
	import urm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// reg_offset[2:0], write_data[10:3], rx_valid[11], rx_byte[19:12], zero fill [23:20].
	input  logic [23:0] s_axis_tdata,
	// func[1:0].
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// read_data[7:0], tx_valid[8], tx_byte[16:9], irq_pulse[17], rx_pop[18], zero fill [23:19].
	output logic [23:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data
);

	logic    irq_route_q;
	logic    valid_s1;
	item_t   item_s1;
	logic    valid_s2;
	result_t result_s2;
	result_t result;
	logic    advance;

	assign cfg_ready = 1'b1;
	assign advance = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			irq_route_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			irq_route_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.func <= func_t'(s_axis_tuser);
			item_s1.reg_offset <= s_axis_tdata[2:0];
			item_s1.write_data <= s_axis_tdata[10:3];
			item_s1.rx_valid <= s_axis_tdata[11];
			item_s1.rx_byte <= s_axis_tdata[19:12];
		end
	end

	urm_regfile u_regfile (
		.clk              (clk),
		.arst_n           (arst_n),
		.advance          (advance),
		.item             (item_s1),
		.irq_route_enable (irq_route_q),
		.result           (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_axis_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata = {5'b00000, result_s2.rx_pop, result_s2.irq_pulse,
		result_s2.tx_byte, result_s2.tx_valid, result_s2.read_data};

endmodule
